// File: design/ffha_pkg.sv
// Shared types, widths and codes for the first-fit heap allocator.
package ffha_pkg;

  localparam int HEAP_UNITS_DEF   = 1024;
  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int SIZE_W           = 11;
  localparam int ADDR_W           = 10;
  localparam int STATUS_W         = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_NO_SPACE   = 3'd1,
    ST_NO_BLOCK   = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_ZERO_SIZE  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    MOP_NONE,
    MOP_INIT,
    MOP_RD_IDX,
    MOP_RD_NEXT,
    MOP_RD_UP,
    MOP_RD_DN,
    MOP_WR_EXACT,
    MOP_WR_COPY,
    MOP_WR_SPLIT_HI,
    MOP_WR_SPLIT_LO,
    MOP_WR_MERGE
  } mem_op_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CLR,
    IDX_INC,
    IDX_DEC,
    IDX_CNT,
    IDX_T1
  } idx_op_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_RD,
    S_CHK,
    S_UP_RD,
    S_UP_WR,
    S_SPLIT_HI,
    S_SPLIT_LO,
    S_NXT_RD,
    S_NXT_CHK,
    S_MRG,
    S_DN_RD,
    S_DN_WR,
    S_FIN,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    mem_op_e mem_op;
    idx_op_e idx_op;
    logic    latch_req;
    logic    take_hit;
    logic    take_prev;
    logic    take_next;
    logic    set_merge;
    logic    cnt_inc;
    logic    cnt_sub;
    logic    res_ok;
    logic    res_err;
    status_e err_code;
  } cmd_t;

  typedef struct packed {
    logic zero_size;
    logic is_free;
    logic hit;
    logic last;
    logic exact;
    logic full;
    logic has_next;
    logic up_done;
    logic dn_done;
  } sts_t;

endpackage

// File: design/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator with coalescing.
// A request is taken when start_i is high and busy_o is low; its result is shown for one
// cycle with done_o high and cannot be held off. After reset the block writes the initial
// segment in S_INIT before it drops busy_o. The segment table is a single RAM, so each
// visited segment is searched with a read state (S_RD) and a check state (S_CHK); an
// allocate that splits then shifts entries up one at a time with a read and a write
// (S_UP_RD, S_UP_WR), and a free that merges shifts entries down the same way (S_DN_RD,
// S_DN_WR). Each result is followed by a return to S_IDLE before the next request.
module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int HEAP_UNITS   = HEAP_UNITS_DEF,
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                func_i,
  input  logic [SIZE_W-1:0]   req_size_i,
  input  logic [ADDR_W-1:0]   req_start_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [ADDR_W-1:0]   block_start_o,
  output logic [ADDR_W-1:0]   block_end_o
);

  cmd_t cmd;
  sts_t sts;

  ffha_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o),
    .done_o (done_o)
  );

  ffha_dp #(
    .HEAP_UNITS  (HEAP_UNITS),
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .func_i       (func_i),
    .req_size_i   (req_size_i),
    .req_start_i  (req_start_i),
    .status_o     (status_o),
    .block_start_o(block_start_o),
    .block_end_o  (block_end_o)
  );

endmodule

// File: design/ffha_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/ffha_ctrl.sv
// Controller state machine that sequences search, split, merge and table shifts.
module ffha_ctrl
  import ffha_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o,
  output logic done_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: state_d = S_IDLE;
      S_IDLE: begin
        if (start_i) state_d = S_RD;
      end
      S_RD: state_d = sts_i.zero_size ? S_DONE : S_CHK;
      S_CHK: begin
        if (sts_i.hit) begin
          if (sts_i.is_free) state_d = S_NXT_RD;
          else if (sts_i.exact) state_d = S_FIN;
          else if (sts_i.full) state_d = S_DONE;
          else state_d = S_UP_RD;
        end else begin
          state_d = sts_i.last ? S_DONE : S_RD;
        end
      end
      S_UP_RD: state_d = sts_i.up_done ? S_SPLIT_HI : S_UP_WR;
      S_UP_WR: state_d = S_UP_RD;
      S_SPLIT_HI: state_d = S_SPLIT_LO;
      S_SPLIT_LO: state_d = S_FIN;
      S_NXT_RD: state_d = sts_i.has_next ? S_NXT_CHK : S_MRG;
      S_NXT_CHK: state_d = S_MRG;
      S_MRG: state_d = S_DN_RD;
      S_DN_RD: state_d = sts_i.dn_done ? S_FIN : S_DN_WR;
      S_DN_WR: state_d = S_DN_RD;
      S_FIN: state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.mem_op = MOP_NONE;
    cmd_o.idx_op = IDX_HOLD;
    cmd_o.err_code = ST_OK;
    case (state_q)
      S_INIT: cmd_o.mem_op = MOP_INIT;
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch_req = 1'b1;
          cmd_o.idx_op = IDX_CLR;
        end
      end
      S_RD: begin
        if (sts_i.zero_size) begin
          cmd_o.res_err = 1'b1;
          cmd_o.err_code = ST_ZERO_SIZE;
        end else begin
          cmd_o.mem_op = MOP_RD_IDX;
        end
      end
      S_CHK: begin
        if (sts_i.hit) begin
          cmd_o.take_hit = 1'b1;
          if (!sts_i.is_free) begin
            if (sts_i.exact) begin
              cmd_o.mem_op = MOP_WR_EXACT;
            end else if (sts_i.full) begin
              cmd_o.res_err = 1'b1;
              cmd_o.err_code = ST_TABLE_FULL;
            end else begin
              cmd_o.idx_op = IDX_CNT;
            end
          end
        end else begin
          cmd_o.take_prev = 1'b1;
          cmd_o.idx_op = IDX_INC;
          if (sts_i.last) begin
            cmd_o.res_err = 1'b1;
            cmd_o.err_code = sts_i.is_free ? ST_NO_BLOCK : ST_NO_SPACE;
          end
        end
      end
      S_UP_RD: begin
        if (!sts_i.up_done) cmd_o.mem_op = MOP_RD_UP;
      end
      S_UP_WR: begin
        cmd_o.mem_op = MOP_WR_COPY;
        cmd_o.idx_op = IDX_DEC;
      end
      S_SPLIT_HI: cmd_o.mem_op = MOP_WR_SPLIT_HI;
      S_SPLIT_LO: begin
        cmd_o.mem_op = MOP_WR_SPLIT_LO;
        cmd_o.cnt_inc = 1'b1;
      end
      S_NXT_RD: begin
        if (sts_i.has_next) cmd_o.mem_op = MOP_RD_NEXT;
      end
      S_NXT_CHK: cmd_o.take_next = 1'b1;
      S_MRG: begin
        cmd_o.mem_op = MOP_WR_MERGE;
        cmd_o.set_merge = 1'b1;
        cmd_o.idx_op = IDX_T1;
      end
      S_DN_RD: begin
        if (sts_i.dn_done) cmd_o.cnt_sub = 1'b1;
        else cmd_o.mem_op = MOP_RD_DN;
      end
      S_DN_WR: begin
        cmd_o.mem_op = MOP_WR_COPY;
        cmd_o.idx_op = IDX_INC;
      end
      S_FIN: cmd_o.res_ok = 1'b1;
      S_DONE: ;
      default: ;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

// File: design/ffha_dp.sv
// Datapath with the segment table, working registers and result registers.
module ffha_dp
  import ffha_pkg::*;
#(
  parameter int HEAP_UNITS   = HEAP_UNITS_DEF,
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic                func_i,
  input  logic [SIZE_W-1:0]   req_size_i,
  input  logic [ADDR_W-1:0]   req_start_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [ADDR_W-1:0]   block_start_o,
  output logic [ADDR_W-1:0]   block_end_o
);

  localparam int HW = $clog2(HEAP_UNITS + 1);
  localparam int DW = (HW > SIZE_W) ? HW : SIZE_W;
  localparam int EW = 2 * DW + 1;
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  logic          func_q;
  logic [DW-1:0] rsz_q, rst_q;
  logic [CW-1:0] idx_q, hit_q, cnt_q;
  logic [DW-1:0] cur_start_q, cur_size_q, prev_start_q, prev_size_q, acc_q;
  logic          prev_free_q, next_free_q;
  logic [DW-1:0] rstart_q, rsize_q;
  logic [STATUS_W-1:0] status_q;
  logic [DW-1:0] bstart_q, bend_q;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [DW-1:0] rd_start, rd_size;
  logic          rd_alloc;
  logic [CW-1:0] t_idx, hit_p1;
  logic [1:0]    rm_cnt;
  logic [DW-1:0] m_start, m_size;

  assign rd_start = rdata[DW-1:0];
  assign rd_size  = rdata[2*DW-1:DW];
  assign rd_alloc = rdata[2*DW];

  assign hit_p1 = hit_q + CW'(1);
  assign t_idx  = prev_free_q ? (hit_q - CW'(1)) : hit_q;
  assign rm_cnt = {1'b0, prev_free_q} + {1'b0, next_free_q};
  assign m_start = prev_free_q ? prev_start_q : cur_start_q;
  assign m_size  = acc_q + (prev_free_q ? prev_size_q : DW'(0));

  always_comb begin
    we    = 1'b0;
    waddr = idx_q[IW-1:0];
    wdata = rdata;
    raddr = idx_q[IW-1:0];
    case (cmd_i.mem_op)
      MOP_INIT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = {1'b0, DW'(HEAP_UNITS), DW'(0)};
      end
      MOP_RD_IDX:  raddr = idx_q[IW-1:0];
      MOP_RD_NEXT: raddr = hit_p1[IW-1:0];
      MOP_RD_UP: begin
        raddr = IW'(idx_q - CW'(1));
      end
      MOP_RD_DN: begin
        raddr = IW'(idx_q + CW'(rm_cnt));
      end
      MOP_WR_EXACT: begin
        we    = 1'b1;
        wdata = {1'b1, rd_size, rd_start};
      end
      MOP_WR_COPY: we = 1'b1;
      MOP_WR_SPLIT_HI: begin
        we    = 1'b1;
        waddr = hit_p1[IW-1:0];
        wdata = {1'b0, cur_size_q - rsz_q, cur_start_q + rsz_q};
      end
      MOP_WR_SPLIT_LO: begin
        we    = 1'b1;
        waddr = hit_q[IW-1:0];
        wdata = {1'b1, rsz_q, cur_start_q};
      end
      MOP_WR_MERGE: begin
        we    = 1'b1;
        waddr = t_idx[IW-1:0];
        wdata = {1'b0, m_size, m_start};
      end
      default: ;
    endcase
  end

  ffha_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_SEGMENTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CW'(1);
      idx_q <= '0;
    end else begin
      case (cmd_i.idx_op)
        IDX_CLR: idx_q <= '0;
        IDX_INC: idx_q <= idx_q + CW'(1);
        IDX_DEC: idx_q <= idx_q - CW'(1);
        IDX_CNT: idx_q <= cnt_q;
        IDX_T1:  idx_q <= t_idx + CW'(1);
        default: ;
      endcase
      if (cmd_i.cnt_inc) cnt_q <= cnt_q + CW'(1);
      else if (cmd_i.cnt_sub) cnt_q <= cnt_q - CW'(rm_cnt);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      func_q      <= func_i;
      rsz_q       <= DW'(req_size_i);
      rst_q       <= DW'(req_start_i);
      prev_free_q <= 1'b0;
    end
    if (cmd_i.take_prev) begin
      prev_start_q <= rd_start;
      prev_size_q  <= rd_size;
      prev_free_q  <= !rd_alloc;
    end
    if (cmd_i.take_hit) begin
      hit_q       <= idx_q;
      cur_start_q <= rd_start;
      cur_size_q  <= rd_size;
      acc_q       <= rd_size;
      next_free_q <= 1'b0;
      rstart_q    <= rd_start;
      rsize_q     <= rsz_q;
    end
    if (cmd_i.take_next && !rd_alloc) begin
      acc_q       <= acc_q + rd_size;
      next_free_q <= 1'b1;
    end
    if (cmd_i.set_merge) begin
      rstart_q <= m_start;
      rsize_q  <= m_size;
    end
    if (cmd_i.res_ok) begin
      status_q <= ST_OK;
      bstart_q <= rstart_q;
      bend_q   <= rstart_q + rsize_q - DW'(1);
    end else if (cmd_i.res_err) begin
      status_q <= cmd_i.err_code;
      bstart_q <= '0;
      bend_q   <= '0;
    end
  end

  always_comb begin
    sts_o.zero_size = (rsz_q == '0);
    sts_o.is_free   = func_q;
    sts_o.hit       = func_q ? (rd_alloc && rd_start == rst_q && rd_size == rsz_q)
                             : (!rd_alloc && rd_size >= rsz_q);
    sts_o.last      = ((idx_q + CW'(1)) == cnt_q);
    sts_o.exact     = (rd_size == rsz_q);
    sts_o.full      = (cnt_q == CW'(MAX_SEGMENTS));
    sts_o.has_next  = (hit_p1 < cnt_q);
    sts_o.up_done   = (idx_q == hit_p1);
    sts_o.dn_done   = (rm_cnt == 2'd0) ||
                      (({1'b0, idx_q} + (CW + 1)'(rm_cnt)) >= {1'b0, cnt_q});
  end

  assign status_o      = status_q;
  assign block_start_o = bstart_q[ADDR_W-1:0];
  assign block_end_o   = bend_q[ADDR_W-1:0];

endmodule

// File: design/ffha_checker.sv
// Port-level checker for the heap allocator and its bind to the top level.
module ffha_checker
  import ffha_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_o,
  input logic                done_o,
  input logic [STATUS_W-1:0] status_o,
  input logic [ADDR_W-1:0]   block_start_o,
  input logic [ADDR_W-1:0]   block_end_o
);

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result beat outside a busy period");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("accepted request did not make the block busy");

  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy_o)) else $error("result beat not followed by idle");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (block_start_o == '0 && block_end_o == '0))
    else $error("error result carries nonzero block fields");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .done_o       (done_o),
  .status_o     (status_o),
  .block_start_o(block_start_o),
  .block_end_o  (block_end_o)
);
